// ===== rtl/core/joint_velocity_root_correction_top_defines.svh =====
// Assertion macros for the joint velocity root correction block.
`ifndef JOINT_VELOCITY_ROOT_CORRECTION_TOP_DEFINES_SVH
`define JOINT_VELOCITY_ROOT_CORRECTION_TOP_DEFINES_SVH
`ifndef SYNTH
`define JVRC_ASSERT_NEVER(lbl, ck, rst_n, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) !(cond)) \
	else $error("assertion failed");
`define JVRC_ASSERT_NEXT(lbl, ck, rst_n, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");
`else
`define JVRC_ASSERT_NEVER(lbl, ck, rst_n, cond)
`define JVRC_ASSERT_NEXT(lbl, ck, rst_n, pre, post)
`endif
`endif

// ===== rtl/core/jvrc_pkg.sv =====
package jvrc_pkg;

	localparam int CORRECTED_JOINTS_DEF = 4;
	localparam int TABLE_ROWS = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int CW = 32;
	localparam int HW = 44;
	localparam int PW = 62;
	localparam int RW = 60;
	localparam logic [5:0] FIRST_RESET = 6'd29;
	localparam logic REG_FIRST_CORRECTED = 1'b0;

	typedef struct packed {
		logic [5:0] joint_index;
		logic signed [15:0] velocity_in;
		logic last_joint;
	} item_t;

	typedef struct packed {
		logic signed [23:0] velocity_out;
		logic was_corrected;
		logic last_out;
	} result_t;

	typedef struct packed {
		logic corr;
		logic [1:0] row;
		logic neg;
		logic [16:0] mag;
		logic signed [15:0] vel;
		logic last;
	} cls_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	localparam logic signed [CW-1:0] COEF [0:31] = '{
		-32'sd1337000, 32'sd7469138, -32'sd802030, 32'sd123745,
		32'sd3432579, 32'sd1452081, -32'sd32381, 32'sd16753,
		32'sd3123577, 32'sd4135125, -32'sd302324, 32'sd50765,
		32'sd6024856, 32'sd2828993, 32'sd103711, 32'sd41357,
		-32'sd1239810048, 32'sd1843593216, -32'sd535553638, 32'sd111902720,
		-32'sd757727232, 32'sd1135935488, -32'sd281667174, 32'sd49806049,
		32'sd3514499, 32'sd1767768, -32'sd60839, 32'sd12843,
		32'sd3466920, 32'sd2093351, -32'sd119210, 32'sd14904
	};

	function automatic logic signed [CW-1:0] coef(input logic [1:0] row, input logic neg,
		input logic [1:0] k);
		return COEF[{row, neg, k}];
	endfunction

endpackage

// ===== rtl/core/jvrc_front.sv =====
module jvrc_front #(
	parameter int CORRECTED_JOINTS = jvrc_pkg::CORRECTED_JOINTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [5:0] first_joint,
	input  jvrc_pkg::item_t item,
	input  logic push,
	input  logic pop,
	output jvrc_pkg::cls_t head,
	output jvrc_pkg::q_status_t status
);
	localparam int QD = jvrc_pkg::QUEUE_DEPTH;
	localparam int AW = $clog2(QD);

	jvrc_pkg::cls_t cls;
	logic [6:0] offset;
	logic signed [16:0] vel_ext;
	jvrc_pkg::cls_t mem_q [0:QD-1];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;

	always_comb begin
		offset = {1'b0, item.joint_index} - {1'b0, first_joint};
		vel_ext = {item.velocity_in[15], item.velocity_in};
		cls.corr = (item.joint_index >= first_joint) &&
			(offset < 7'(CORRECTED_JOINTS)) && (offset < 7'(jvrc_pkg::TABLE_ROWS));
		cls.row = offset[1:0];
		cls.neg = item.velocity_in[15];
		cls.mag = cls.neg ? 17'(-vel_ext) : 17'(vel_ext);
		cls.vel = item.velocity_in;
		cls.last = item.last_joint;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	assign head = mem_q[rd_q];
	assign status.full = (cnt_q == (AW+1)'(QD));
	assign status.empty = (cnt_q == '0);
endmodule

// ===== rtl/core/jvrc_sqrt.sv =====
module jvrc_sqrt #(
	parameter int W = 60
) (
	input  logic clk,
	input  logic en,
	input  logic [W-1:0] x,
	output logic [W/2-1:0] root
);
	localparam int N = W / 2;

	logic [N+1:0] rem_q [1:N];
	logic [N-1:0] root_q [1:N];
	logic [W-1:0] x_q [1:N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [N+1:0] rem_p, rem_n, trial;
		logic [N-1:0] root_p;
		logic [W-1:0] x_p;
		logic ge;
		if (i == 0) begin : g_first
			assign rem_p = '0;
			assign root_p = '0;
			assign x_p = x;
		end else begin : g_next
			assign rem_p = rem_q[i];
			assign root_p = root_q[i];
			assign x_p = x_q[i];
		end
		always_comb begin
			rem_n = {rem_p[N-1:0], x_p[W-1:W-2]};
			trial = {root_p, 2'b01};
			ge = (rem_n >= trial);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i+1] <= ge ? rem_n - trial : rem_n;
				root_q[i+1] <= {root_p[N-2:0], ge};
				x_q[i+1] <= {x_p[W-3:0], 2'b00};
			end
		end
	end

	assign root = root_q[N];
endmodule

// ===== rtl/core/jvrc_back.sv =====
module jvrc_back (
	input  logic clk,
	input  logic arst_n,
	input  jvrc_pkg::cls_t head,
	input  logic head_valid,
	output logic pop,
	output jvrc_pkg::result_t result,
	output logic result_valid,
	input  logic result_stall
);
	localparam int HW = jvrc_pkg::HW;
	localparam int PW = jvrc_pkg::PW;
	localparam int RW = jvrc_pkg::RW;
	localparam int SQ1_N = RW / 2;
	localparam int SQ2_W = SQ1_N + 8;
	localparam int SQ2_N = SQ2_W / 2;
	localparam int MT_LEN = 9 + SQ1_N + SQ2_N;

	logic en;
	jvrc_pkg::cls_t mt_q [1:MT_LEN];
	logic vld_q [1:MT_LEN];
	logic signed [PW-1:0] prod_s2, prod_s4, prod_s6, prod_s8;
	logic signed [HW-1:0] h_s3, h_s5, h_s7;
	logic [RW-1:0] rad_s9;
	logic [SQ1_N-1:0] root1;
	logic [SQ2_N-1:0] root2;
	jvrc_pkg::result_t res_n;
	jvrc_pkg::result_t result_q;
	logic result_valid_q;
	jvrc_pkg::cls_t mo;
	logic signed [23:0] mag_out;

	assign en = !(result_valid_q && result_stall);
	assign pop = en && head_valid;

	always_ff @(posedge clk) begin
		if (en) begin
			mt_q[1] <= head;
			for (int i = 2; i <= MT_LEN; i++) mt_q[i] <= mt_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= MT_LEN; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[1] <= head_valid;
			for (int i = 2; i <= MT_LEN; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= PW'(jvrc_pkg::coef(mt_q[1].row, mt_q[1].neg, 2'd0) *
				$signed({1'b0, mt_q[1].mag}));
			h_s3 <= HW'(prod_s2 >>> 12) +
				HW'(jvrc_pkg::coef(mt_q[2].row, mt_q[2].neg, 2'd1));
			prod_s4 <= h_s3 * $signed({1'b0, mt_q[3].mag});
			h_s5 <= HW'(prod_s4 >>> 12) +
				HW'(jvrc_pkg::coef(mt_q[4].row, mt_q[4].neg, 2'd2));
			prod_s6 <= h_s5 * $signed({1'b0, mt_q[5].mag});
			h_s7 <= HW'(prod_s6 >>> 12) +
				HW'(jvrc_pkg::coef(mt_q[6].row, mt_q[6].neg, 2'd3));
			prod_s8 <= h_s7 * $signed({1'b0, mt_q[7].mag});
			rad_s9 <= (prod_s8 <= 0) ? '0 : {prod_s8[RW-5:0], 4'b0000};
		end
	end

	jvrc_sqrt #(.W(RW)) u_sqrt1 (
		.clk(clk),
		.en(en),
		.x(rad_s9),
		.root(root1)
	);

	jvrc_sqrt #(.W(SQ2_W)) u_sqrt2 (
		.clk(clk),
		.en(en),
		.x({root1, 8'h00}),
		.root(root2)
	);

	always_comb begin
		mo = mt_q[MT_LEN];
		mag_out = $signed(24'(root2));
		res_n.velocity_out = mo.corr ? (mo.neg ? -mag_out : mag_out) : 24'(mo.vel);
		res_n.was_corrected = mo.corr;
		res_n.last_out = mo.last;
	end

	always_ff @(posedge clk) begin
		if (en) result_q <= res_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (en) begin
			result_valid_q <= vld_q[MT_LEN];
		end
	end

	assign result = result_q;
	assign result_valid = result_valid_q;
endmodule

// ===== rtl/core/joint_velocity_root_correction_top.sv =====
// Throughput: one item per cycle unless a valid result is stalled; a four-entry
// queue decouples intake from the 58-stage arithmetic pipeline, whose length is
// set by the two bit-per-stage square root units.
// Reset clears the queue, the pipeline valid bits and sets the first corrected
// joint register to 29.
`include "joint_velocity_root_correction_top_defines.svh"

module joint_velocity_root_correction_top #(
	parameter int CORRECTED_JOINTS = jvrc_pkg::CORRECTED_JOINTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  jvrc_pkg::item_t item,
	output logic result_valid,
	input  logic result_stall,
	output jvrc_pkg::result_t result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [5:0] first_q;
	logic push, pop;
	jvrc_pkg::cls_t head;
	jvrc_pkg::q_status_t q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= jvrc_pkg::FIRST_RESET;
		end else if (psel && penable && pwrite && paddr[2] == jvrc_pkg::REG_FIRST_CORRECTED) begin
			first_q <= pwdata[5:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == jvrc_pkg::REG_FIRST_CORRECTED) ? {26'd0, first_q} : 32'd0;

	assign item_stall = q_status.full;
	assign push = item_valid && !item_stall;

	jvrc_front #(.CORRECTED_JOINTS(CORRECTED_JOINTS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.first_joint(first_q),
		.item(item),
		.push(push),
		.pop(pop),
		.head(head),
		.status(q_status)
	);

	jvrc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.head_valid(!q_status.empty),
		.pop(pop),
		.result(result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

	`JVRC_ASSERT_NEVER(a_q_full_empty, clk, arst_n, q_status.full && q_status.empty)
	`JVRC_ASSERT_NEXT(a_push_fills, clk, arst_n, push, !q_status.empty)
	`JVRC_ASSERT_NEXT(a_full_holds, clk, arst_n, q_status.full && !pop, item_stall)
endmodule
